@@ hw/rtl/dct8x8_pkg.sv @@
// ----------------------------------------------------------------------------
// dct8x8_pkg
// Shared types and constants of the 8x8 integer DCT: block geometry, the
// 8-point basis matrix, sequencer states and the MAC control bundle.
// ----------------------------------------------------------------------------
package dct8x8_pkg;

  // Default sample magnitude (sample width is one more for the sign)
  localparam int SAMPLE_MAGNITUDE_BITS_DEF = 8;

  // Block geometry
  localparam int BLOCK_SIZE  = 8;
  localparam int BLOCK_AREA  = 64;
  localparam int IDX_W       = 3;   // index within a row or column
  localparam int ADDR_W      = 6;   // index within the block

  // Basis coefficient and output coefficient widths
  localparam int BASIS_W     = 8;
  localparam int COEF_WIDTH  = 28;
  localparam int OUT_DATA_W  = ((COEF_WIDTH + 7) / 8) * 8;

  // 8-point basis, row k (frequency) by column n (sample), row-major
  localparam logic signed [BASIS_W-1:0] DCT_MATRIX [BLOCK_AREA] = '{
     8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,
     8'sd89,  8'sd75,  8'sd50,  8'sd18, -8'sd18, -8'sd50, -8'sd75, -8'sd89,
     8'sd83,  8'sd36, -8'sd36, -8'sd83, -8'sd83, -8'sd36,  8'sd36,  8'sd83,
     8'sd75, -8'sd18, -8'sd89, -8'sd50,  8'sd50,  8'sd89,  8'sd18, -8'sd75,
     8'sd64, -8'sd64, -8'sd64,  8'sd64,  8'sd64, -8'sd64, -8'sd64,  8'sd64,
     8'sd50, -8'sd89,  8'sd18,  8'sd75, -8'sd75, -8'sd18,  8'sd89, -8'sd50,
     8'sd36, -8'sd83,  8'sd83, -8'sd36, -8'sd36,  8'sd83, -8'sd83,  8'sd36,
     8'sd18, -8'sd50,  8'sd75, -8'sd89,  8'sd89, -8'sd75,  8'sd50, -8'sd18
  };

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROW_MAC,
    ST_ROW_DRAIN,
    ST_COL_MAC,
    ST_COL_DRAIN,
    ST_COL_EMIT
  } seq_state_t;

  // Per-term control issued alongside a memory read
  typedef struct packed {
    logic issue;     // a term is read this cycle
    logic first;     // first term of a coefficient
    logic last;      // last term of a coefficient
    logic col_pass;  // term comes from the row result store
  } mac_ctrl_t;

endpackage

@@ hw/rtl/dct8x8_ram.sv @@
// ----------------------------------------------------------------------------
// dct8x8_ram
// 64-entry simple dual-port memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module dct8x8_ram
  import dct8x8_pkg::*;
#(
  parameter int WIDTH = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [BLOCK_AREA];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/dct8x8_mac.sv @@
// ----------------------------------------------------------------------------
// dct8x8_mac
// Shared multiply-accumulate unit. Takes one term per cycle from either
// store, multiplies it by the basis coefficient and sums eight terms into
// one transform output; flags done when the last term is in.
// ----------------------------------------------------------------------------
module dct8x8_mac
  import dct8x8_pkg::*;
#(
  parameter int SAMPLE_MAGNITUDE_BITS = SAMPLE_MAGNITUDE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctrl_t                ctrl,
  input  logic signed [BASIS_W-1:0] basis,
  input  logic signed [SAMPLE_MAGNITUDE_BITS:0]      sample_rd,
  input  logic signed [SAMPLE_MAGNITUDE_BITS+9:0]    row_rd,
  output logic signed [SAMPLE_MAGNITUDE_BITS+19:0]   acc,
  output logic                     done
);

  localparam int SW = SAMPLE_MAGNITUDE_BITS + 1;
  localparam int RW = SW + 9;
  localparam int PW = RW + BASIS_W;
  localparam int AW = RW + 10;

  // Stage 1: aligned with the registered memory read
  mac_ctrl_t                 s1_r;
  logic signed [BASIS_W-1:0] basis_s1_r;
  logic signed [RW-1:0]      data_s1;

  // Stage 2: product
  mac_ctrl_t                 s2_r;
  logic signed [PW-1:0]      prod_r;
  logic signed [PW-1:0]      prod_nxt;

  // Accumulator
  logic signed [AW-1:0]      acc_r;
  logic signed [AW-1:0]      acc_nxt;
  logic                      done_r;

  // Control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= ctrl;
      s2_r   <= s1_r;
      done_r <= s2_r.issue & s2_r.last;
    end
  end

  // Operand select and multiply
  always_comb begin
    data_s1  = s1_r.col_pass ? row_rd
                             : {{(RW-SW){sample_rd[SW-1]}}, sample_rd};
    prod_nxt = PW'(data_s1) * PW'(basis_s1_r);
  end

  // Accumulate, restarting on the first term
  always_comb begin
    acc_nxt = s2_r.first ? AW'(prod_r) : acc_r + AW'(prod_r);
  end

  always_ff @(posedge clk) begin
    basis_s1_r <= basis;
    if (s1_r.issue) begin
      prod_r <= prod_nxt;
    end
    if (s2_r.issue) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

@@ hw/rtl/dct8x8_seq.sv @@
// ----------------------------------------------------------------------------
// dct8x8_seq
// Sequencer: loads 64 samples, then steps the shared MAC through the row
// pass (into the row store) and the column pass (out to the result port).
// ----------------------------------------------------------------------------
module dct8x8_seq
  import dct8x8_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // input side
  input  logic                      in_tvalid,
  output logic                      in_tready,
  output logic                      smp_we,
  output logic [ADDR_W-1:0]         smp_waddr,
  // store reads and MAC control
  output logic [ADDR_W-1:0]         rd_addr,
  output logic signed [BASIS_W-1:0] basis,
  output mac_ctrl_t                 mac_ctrl,
  input  logic                      mac_done,
  // row store write
  output logic                      row_we,
  output logic [ADDR_W-1:0]         row_waddr,
  // result emit
  input  logic                      out_free,
  output logic                      emit,
  output logic                      emit_last
);

  seq_state_t         state_r, state_nxt;
  // block index: sample count while loading, {outer,inner} during passes
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]   term_r, term_nxt;
  logic [IDX_W-1:0]   outer, inner;
  logic               idx_end;

  assign outer   = idx_r[ADDR_W-1:IDX_W];
  assign inner   = idx_r[IDX_W-1:0];
  assign idx_end = (idx_r == ADDR_W'(BLOCK_AREA - 1));

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      idx_r   <= '0;
      term_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      term_r  <= term_nxt;
    end
  end

  // Next state and outputs
  always_comb begin
    state_nxt         = state_r;
    idx_nxt           = idx_r;
    term_nxt          = term_r;
    in_tready         = 1'b0;
    smp_we            = 1'b0;
    smp_waddr         = idx_r;
    rd_addr           = {outer, term_r};
    basis             = DCT_MATRIX[{inner, term_r}];
    mac_ctrl          = '0;
    mac_ctrl.first    = (term_r == '0);
    mac_ctrl.last     = (term_r == IDX_W'(BLOCK_SIZE - 1));
    row_we            = 1'b0;
    row_waddr         = idx_r;
    emit              = 1'b0;
    emit_last         = idx_end;

    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          smp_we  = 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (idx_end) begin
            state_nxt = ST_ROW_MAC;
          end
        end
      end

      // row pass: term n of sample row outer, frequency inner
      ST_ROW_MAC: begin
        mac_ctrl.issue = 1'b1;
        term_nxt       = term_r + 1'b1;
        if (mac_ctrl.last) begin
          state_nxt = ST_ROW_DRAIN;
        end
      end

      ST_ROW_DRAIN: begin
        if (mac_done) begin
          row_we  = 1'b1;
          idx_nxt = idx_r + 1'b1;
          state_nxt = idx_end ? ST_COL_MAC : ST_ROW_MAC;
        end
      end

      // column pass: term n of column inner, frequency outer
      ST_COL_MAC: begin
        rd_addr           = {term_r, inner};
        basis             = DCT_MATRIX[{outer, term_r}];
        mac_ctrl.issue    = 1'b1;
        mac_ctrl.col_pass = 1'b1;
        term_nxt          = term_r + 1'b1;
        if (mac_ctrl.last) begin
          state_nxt = ST_COL_DRAIN;
        end
      end

      ST_COL_DRAIN: begin
        if (mac_done) begin
          state_nxt = ST_COL_EMIT;
        end
      end

      ST_COL_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          idx_nxt = idx_r + 1'b1;
          state_nxt = idx_end ? ST_LOAD : ST_COL_MAC;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

@@ hw/rtl/dct_2d_8x8_integer.sv @@
// ----------------------------------------------------------------------------
// dct_2d_8x8_integer
// 8x8 two-dimensional integer DCT (8-point integer basis, direct matrix
// multiply), row pass then column pass, no scaling between passes.
//
// Usage:
//   Input stream in_*: one signed sample per transaction, 64 per block in
//   row-major order. Output stream out_*: the 64 coefficients in row-major
//   order (vertical frequency, then horizontal), tlast on the 64th.
//   The block takes samples only while loading; after the 64th sample
//   in_tready stays low until the last coefficient of that block has been
//   moved into the output register.
//   Schedule: one shared multiply-accumulate unit computes every transform
//   output as eight terms. Each row-pass output takes eight reads, then a
//   pipeline drain; each column-pass output takes eight reads, a pipeline
//   drain and an emit.
//   A stalled receiver holds the output register; the sequencer waits
//   before emitting the next coefficient and nothing is dropped.
//   Reset (rst_n low, synchronous) empties the output register and
//   restarts the sample count at the start of a block.
// ----------------------------------------------------------------------------
module dct_2d_8x8_integer
  import dct8x8_pkg::*;
#(
  parameter int SAMPLE_MAGNITUDE_BITS = SAMPLE_MAGNITUDE_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // in_tdata: [SAMPLE_MAGNITUDE_BITS:0] sample, rest zero fill
  input  logic [((SAMPLE_MAGNITUDE_BITS + 8) / 8) * 8 - 1:0] in_tdata,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // out_tdata: [27:0] coefficient, rest zero fill
  output logic [OUT_DATA_W-1:0]                      out_tdata,
  output logic                                       out_tlast,  // last_of_block
  output logic                                       out_tvalid,
  input  logic                                       out_tready
);

  localparam int SW = SAMPLE_MAGNITUDE_BITS + 1;
  localparam int RW = SW + 9;
  localparam int AW = RW + 10;

  logic                      smp_we;
  logic [ADDR_W-1:0]         smp_waddr;
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [BASIS_W-1:0] basis;
  mac_ctrl_t                 mac_ctrl;
  logic                      mac_done;
  logic                      row_we;
  logic [ADDR_W-1:0]         row_waddr;
  logic                      out_free;
  logic                      emit;
  logic                      emit_last;
  logic signed [SW-1:0]      sample_rd;
  logic signed [RW-1:0]      row_rd;
  logic signed [AW-1:0]      acc;

  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [COEF_WIDTH-1:0]     out_coef_r;
  logic                      out_tlast_r;

  // Sequencer
  dct8x8_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .smp_we    (smp_we),
    .smp_waddr (smp_waddr),
    .rd_addr   (rd_addr),
    .basis     (basis),
    .mac_ctrl  (mac_ctrl),
    .mac_done  (mac_done),
    .row_we    (row_we),
    .row_waddr (row_waddr),
    .out_free  (out_free),
    .emit      (emit),
    .emit_last (emit_last)
  );

  // Sample store
  dct8x8_ram #(.WIDTH(SW)) u_sample_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (smp_waddr),
    .wdata (in_tdata[SW-1:0]),
    .raddr (rd_addr),
    .rdata (sample_rd)
  );

  // Row result store
  dct8x8_ram #(.WIDTH(RW)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (acc[RW-1:0]),
    .raddr (rd_addr),
    .rdata (row_rd)
  );

  // Shared multiply-accumulate unit
  dct8x8_mac #(.SAMPLE_MAGNITUDE_BITS(SAMPLE_MAGNITUDE_BITS)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mac_ctrl),
    .basis     (basis),
    .sample_rd (sample_rd),
    .row_rd    (row_rd),
    .acc       (acc),
    .done      (mac_done)
  );

  // Output register
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (emit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Sign-extend or wrap the accumulator to the coefficient width
  always_ff @(posedge clk) begin
    if (emit) begin
      out_coef_r  <= COEF_WIDTH'(acc);
      out_tlast_r <= emit_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-COEF_WIDTH){1'b0}}, out_coef_r};
  assign out_tlast  = out_tlast_r;

endmodule
